// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NCI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/nci_pkg.sv -----
// Package with widths, constants, tables and state types of the integrator.
package nci_pkg;

	localparam int MAX_INTERVALS_DEF = 1024;

	localparam int N_W    = 11;  // panel count
	localparam int TOT_W  = 14;  // sub-step count n*s
	localparam int DEN_W  = 20;  // divisor width, n*90 or n*288
	localparam int NUM_W  = 58;  // dividend width
	localparam int Q0_W   = 32;  // node step quotient
	localparam int QN_W   = 33;  // running node offset
	localparam int NODE_W = 35;  // signed Q4.28 node
	localparam int MAG_W  = 31;  // clamped node magnitude
	localparam int MA_W   = 38;  // multiplier operand a
	localparam int MB_W   = 33;  // multiplier operand b
	localparam int MP_W   = MA_W + MB_W;
	localparam int MSPL   = 19;  // split point of operand a
	localparam int M5_W   = 44;
	localparam int XY_W   = 34;  // CORDIC x and y, Q2.30
	localparam int SIN_W  = 36;  // sine in Q32
	localparam int F_W    = 44;  // function value, Q12.32
	localparam int SP_W   = 54;  // weighted panel sum
	localparam int ACC_W  = 50;  // integral accumulator
	localparam int OUT_W  = 48;
	localparam int ITERS  = 28;

	localparam logic signed [NODE_W-1:0] PI_Q28      = 35'sd843314857;
	localparam logic signed [NODE_W-1:0] TWO_PI_Q28  = 35'sd1686629713;
	localparam logic signed [NODE_W-1:0] HALF_PI_Q28 = 35'sd421657428;
	localparam logic signed [XY_W-1:0]   GAIN_Q30    = 34'sd652032874;
	localparam logic [NODE_W-1:0]        FIVE_Q28    = 35'd1342177280;
	localparam logic signed [F_W+1:0]    F_MAX       = 46'sd8796093022207;
	localparam logic signed [F_W+1:0]    F_MIN       = -46'sd8796093022208;
	localparam logic signed [ACC_W-1:0]  R_MAX       = 50'sd140737488355327;
	localparam logic signed [ACC_W-1:0]  R_MIN       = -50'sd140737488355328;

	localparam logic RULE_BOOLE = 1'b0;
	localparam logic RULE_FIVE  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_SETUP, S_DIV0, S_DIV0W, S_NODE, S_EVAL, S_MUL, S_CWAIT,
		S_ACC, S_SUM, S_PDIV, S_PWAIT, S_DONE
	} nci_state_t;

	typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ITER} nci_cstate_t;

	function automatic logic signed [NODE_W-1:0] atan_q28(input logic [4:0] i);
		logic signed [NODE_W-1:0] v;
		case (i)
			5'd0:  v = 35'sd210828714;
			5'd1:  v = 35'sd124459457;
			5'd2:  v = 35'sd65760959;
			5'd3:  v = 35'sd33381290;
			5'd4:  v = 35'sd16755422;
			5'd5:  v = 35'sd8385879;
			5'd6:  v = 35'sd4193963;
			5'd7:  v = 35'sd2097109;
			5'd8:  v = 35'sd1048571;
			5'd9:  v = 35'sd524287;
			default: v = (i < 5'd28) ? (35'sd1 <<< (5'd28 - i)) : 35'sd0;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] weight(input logic rule, input logic [2:0] k);
		logic [6:0] w;
		if (rule == RULE_FIVE) begin
			case (k)
				3'd0, 3'd5: w = 7'd19;
				3'd1, 3'd4: w = 7'd75;
				default:    w = 7'd50;
			endcase
		end else begin
			case (k)
				3'd0, 3'd4: w = 7'd7;
				3'd1, 3'd3: w = 7'd32;
				default:    w = 7'd12;
			endcase
		end
		return w;
	endfunction

endpackage

// ----- rtl/newton_cotes_integrator_top.sv -----
// Top level: sequencer of the composite Newton-Cotes integrator for sin(x)+x^5.
//
// Channel   Dir  Payload (lowest bit up)
// s_axis    in   tdata: lower_bound[3:0], upper_bound[7:4], intervals[18:8]; tuser: rule
// m_axis    out  tdata: integral[47:0]; tuser: invalid
//
// Each panel has s = 4 or 5 sub-steps, set by the rule.
// A node whose angle lies outside [-pi, pi] is first wrapped into that range.
// The 28-step CORDIC sets the cost of each function value, the bit-serial divider
// the cost of each panel. A zero panel count goes from idle straight to the done state.
// s_axis_tready is high only while idle; a waiting result does not block acceptance.
// Reset clears all control state; no clearing pass is needed.
module newton_cotes_integrator_top
	import nci_pkg::*;
#(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // lower_bound, upper_bound, intervals, zero pad
	input  logic [0:0]  s_axis_tuser,  // rule
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // integral
	output logic [0:0]  m_axis_tuser   // invalid
);
	localparam logic [16:0] MAXI = 17'(MAX_INTERVALS);

	nci_state_t state_q, state_d;

	logic signed [3:0]        lo_q;
	logic signed [4:0]        span_q;
	logic [N_W-1:0]           n_q, l_q;
	logic                     rule_q, inv_q;
	logic [TOT_W-1:0]         total_q, r0_q, rn_q;
	logic [DEN_W-1:0]         dnom_q;
	logic [Q0_W-1:0]          q0_q;
	logic [QN_W-1:0]          qn_q;
	logic [2:0]               k_q;
	logic signed [NODE_W-1:0] node_q;
	logic [MAG_W-1:0]         m_q;
	logic [M5_W-1:0]          m5_q;
	logic [1:0]               mstep_q;
	logic                     cdone_q;
	logic signed [F_W-1:0]    f_q;
	logic signed [SP_W-1:0]   sp_q;
	logic                     neg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;
	logic                     out_inv_q;

	logic                     accept, out_free;
	logic signed [3:0]        in_lo, in_hi;
	logic [N_W-1:0]           in_n;
	logic [2:0]               steps;

	logic                     div_start, div_done;
	logic [NUM_W-1:0]         div_num, div_quo;
	logic [DEN_W-1:0]         div_den, div_rem;
	logic                     mul_start, mul_done;
	logic [MA_W-1:0]          mul_a;
	logic [MB_W-1:0]          mul_b;
	logic [MP_W-1:0]          mul_p;
	logic [MP_W:0]            r28, r24;
	logic                     cor_done;
	logic signed [SIN_W-1:0]  cor_sine;

	logic [TOT_W:0]           r_sum;
	logic                     wrap;
	logic signed [NODE_W-1:0] qs, node_c;
	logic [NODE_W-1:0]        nabs;
	logic [MAG_W-1:0]         m_c;
	logic signed [M5_W:0]     p_c;
	logic signed [F_W+1:0]    fsum;
	logic signed [F_W-1:0]    f_c;
	logic signed [F_W+7:0]    wprod;
	logic signed [SP_W-1:0]   sp_nx;
	logic signed [SP_W+4:0]   pnum;
	logic [SP_W+4:0]          pmag;
	logic [ACC_W-1:0]         qext;
	logic [OUT_W-1:0]         sat_out;

	assign in_lo  = s_axis_tdata[3:0];
	assign in_hi  = s_axis_tdata[7:4];
	assign in_n   = (17'(s_axis_tdata[18:8]) > MAXI) ? MAXI[N_W-1:0] : s_axis_tdata[18:8];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign steps  = (rule_q == RULE_FIVE) ? 3'd5 : 3'd4;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_inv_q;

	// Next node offset: add the step quotient and carry the remainder.
	assign r_sum = {1'b0, rn_q} + {1'b0, r0_q};
	assign wrap  = r_sum >= {1'b0, total_q};

	assign qs     = span_q[4] ? -$signed({2'b0, qn_q}) : $signed({2'b0, qn_q});
	assign node_c = $signed({{3{lo_q[3]}}, lo_q, 28'd0}) + qs;
	assign nabs   = node_c[NODE_W-1] ? NODE_W'(-node_c) : NODE_W'(node_c);
	assign m_c    = (nabs > FIVE_Q28) ? FIVE_Q28[MAG_W-1:0] : nabs[MAG_W-1:0];

	assign r28 = ({1'b0, mul_p} + ((MP_W+1)'(1) << 27)) >> 28;
	assign r24 = ({1'b0, mul_p} + ((MP_W+1)'(1) << 23)) >> 24;

	assign p_c  = node_q[NODE_W-1] ? -$signed({1'b0, m5_q}) : $signed({1'b0, m5_q});
	assign fsum = (F_W+2)'(cor_sine) + (F_W+2)'(p_c);
	assign f_c  = (fsum > F_MAX) ? F_W'(F_MAX) : (fsum < F_MIN) ? F_W'(F_MIN) : F_W'(fsum);

	assign wprod = $signed({1'b0, weight(rule_q, k_q)}) * f_q;
	assign sp_nx = sp_q + SP_W'(wprod);

	assign pnum = (SP_W+5)'(span_q) * (SP_W+5)'(sp_q);
	assign pmag = pnum[SP_W+4] ? (SP_W+5)'(-pnum) : (SP_W+5)'(pnum);
	assign qext = ACC_W'(div_quo[ACC_W-2:0]);

	assign sat_out = (acc_q > R_MAX) ? R_MAX[OUT_W-1:0] :
	                 (acc_q < R_MIN) ? R_MIN[OUT_W-1:0] : acc_q[OUT_W-1:0];

	always_comb begin
		div_start = (state_q == S_DIV0) || (state_q == S_PDIV);
		if (state_q == S_DIV0) begin
			div_num = NUM_W'({(span_q[4] ? 4'(-span_q) : 4'(span_q)), 28'd0});
			div_den = DEN_W'(total_q);
		end else begin
			div_num = NUM_W'(pmag) + NUM_W'(dnom_q >> 1);
			div_den = dnom_q;
		end
	end

	always_comb begin
		mul_start = (state_q == S_EVAL) || (state_q == S_MUL && mul_done && mstep_q != 2'd2);
		if (state_q == S_MUL && mstep_q == 2'd0) begin
			mul_a = MA_W'(r28[MB_W-1:0]);
			mul_b = r28[MB_W-1:0];
		end else if (state_q == S_MUL) begin
			mul_a = r28[MA_W-1:0];
			mul_b = MB_W'(m_q);
		end else begin
			mul_a = MA_W'(m_q);
			mul_b = MB_W'(m_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = (s_axis_tdata[18:8] == '0) ? S_DONE : S_SETUP;
			S_SETUP: state_d = S_DIV0;
			S_DIV0:  state_d = S_DIV0W;
			S_DIV0W: if (div_done) state_d = S_NODE;
			S_NODE:  state_d = S_EVAL;
			S_EVAL:  state_d = S_MUL;
			S_MUL:   if (mul_done && mstep_q == 2'd2) state_d = S_CWAIT;
			S_CWAIT: if (cdone_q || cor_done) state_d = S_ACC;
			S_ACC:   state_d = S_SUM;
			S_SUM:   state_d = (k_q == steps) ? S_PDIV : S_NODE;
			S_PDIV:  state_d = S_PWAIT;
			S_PWAIT: if (div_done) state_d = (l_q == n_q - 1'b1) ? S_DONE : S_NODE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cdone_q     <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (state_q == S_EVAL)
				cdone_q <= 1'b0;
			else if (cor_done)
				cdone_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				lo_q   <= in_lo;
				span_q <= 5'(in_hi) - 5'(in_lo);
				n_q    <= in_n;
				rule_q <= s_axis_tuser[0];
				inv_q  <= (s_axis_tdata[18:8] == '0);
				acc_q  <= '0;
			end
			S_SETUP: begin
				total_q <= TOT_W'(n_q) * TOT_W'(steps);
				dnom_q  <= DEN_W'(n_q) * ((rule_q == RULE_FIVE) ? DEN_W'(288) : DEN_W'(90));
			end
			S_DIV0W: if (div_done) begin
				q0_q <= div_quo[Q0_W-1:0];
				r0_q <= div_rem[TOT_W-1:0];
				qn_q <= '0;
				rn_q <= total_q >> 1;
				k_q  <= '0;
				l_q  <= '0;
				sp_q <= '0;
			end
			S_NODE: begin
				node_q <= node_c;
				m_q    <= m_c;
			end
			S_EVAL: mstep_q <= '0;
			S_MUL: if (mul_done) begin
				mstep_q <= mstep_q + 1'b1;
				if (mstep_q == 2'd2)
					m5_q <= r24[M5_W-1:0];
			end
			S_ACC: f_q <= f_c;
			S_SUM: begin
				sp_q <= sp_nx;
				if (k_q != steps) begin
					k_q  <= k_q + 1'b1;
					rn_q <= wrap ? TOT_W'(r_sum - {1'b0, total_q}) : r_sum[TOT_W-1:0];
					qn_q <= qn_q + QN_W'(q0_q) + QN_W'(wrap);
				end
			end
			S_PDIV: neg_q <= pnum[SP_W+4];
			S_PWAIT: if (div_done) begin
				acc_q <= acc_q + (neg_q ? -$signed(qext) : $signed(qext));
				// The shared end node opens the next panel with the first weight.
				l_q  <= l_q + 1'b1;
				sp_q <= SP_W'($signed({1'b0, weight(rule_q, 3'd0)}) * f_q);
				k_q  <= 3'd1;
				rn_q <= wrap ? TOT_W'(r_sum - {1'b0, total_q}) : r_sum[TOT_W-1:0];
				qn_q <= qn_q + QN_W'(q0_q) + QN_W'(wrap);
			end
			S_DONE: if (out_free) begin
				out_data_q <= inv_q ? '0 : sat_out;
				out_inv_q  <= inv_q;
			end
			default: ;
		endcase
	end

	nci_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	nci_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	nci_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_EVAL),
		.angle  (node_q),
		.done   (cor_done),
		.sine   (cor_sine)
	);
endmodule

// ----- rtl/nci_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module nci_div
	import nci_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W-1:0] remainder
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, dsr_q}) : trial[DEN_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ----- rtl/nci_mul.sv -----
// Unsigned multiplier that forms its product from two partial products.
module nci_mul
	import nci_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MA_W-1:0] a,
	input  logic [MB_W-1:0] b,
	output logic            done,
	output logic [MP_W-1:0] product
);
	localparam int LO_W = MSPL + MB_W;
	localparam int HI_W = (MA_W - MSPL) + MB_W;

	logic [MA_W-1:0] a_q;
	logic [MB_W-1:0] b_q;
	logic [LO_W-1:0] lo_q;
	logic [MP_W-1:0] p_q;
	logic            ph1_q, ph2_q, done_q;
	logic [HI_W-1:0] hi;

	assign hi = HI_W'(a_q[MA_W-1:MSPL]) * HI_W'(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph1_q  <= 1'b0;
			ph2_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ph1_q  <= start;
			ph2_q  <= ph1_q;
			done_q <= ph2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (ph1_q)
			lo_q <= LO_W'(a_q[MSPL-1:0]) * LO_W'(b_q);
		if (ph2_q)
			p_q <= (MP_W'(hi) << MSPL) + MP_W'(lo_q);
	end

	assign done    = done_q;
	assign product = p_q;
endmodule

// ----- rtl/nci_cordic.sv -----
// Sine by range reduction and iterative rotation-mode CORDIC.
module nci_cordic
	import nci_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [NODE_W-1:0] angle,
	output logic                     done,
	output logic signed [SIN_W-1:0]  sine
);
	nci_cstate_t st_q, st_d;

	logic signed [NODE_W-1:0] z_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic [4:0]               i_q;
	logic                     done_q;
	logic signed [SIN_W-1:0]  sine_q;
	logic signed [XY_W-1:0]   dx, dy, x_nx, y_nx;
	logic signed [NODE_W-1:0] z_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			C_IDLE: if (start) st_d = C_RED;
			C_RED:  if (z_q <= PI_Q28 && z_q >= -PI_Q28) st_d = C_FOLD;
			C_FOLD: st_d = C_ITER;
			C_ITER: if (i_q == 5'(ITERS - 1)) st_d = C_IDLE;
			default: st_d = C_IDLE;
		endcase
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	always_comb begin
		if (z_q >= 0) begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			z_nx = z_q - atan_q28(i_q);
		end else begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			z_nx = z_q + atan_q28(i_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == C_ITER) && (i_q == 5'(ITERS - 1));
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: if (start) z_q <= angle;
			C_RED: begin
				if (z_q > PI_Q28)
					z_q <= z_q - TWO_PI_Q28;
				else if (z_q < -PI_Q28)
					z_q <= z_q + TWO_PI_Q28;
			end
			C_FOLD: begin
				// Fold the outer quarters back so the rotation stays convergent.
				if (z_q > HALF_PI_Q28)
					z_q <= PI_Q28 - z_q;
				else if (z_q < -HALF_PI_Q28)
					z_q <= -PI_Q28 - z_q;
				x_q <= GAIN_Q30;
				y_q <= '0;
				i_q <= '0;
			end
			C_ITER: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
				i_q <= i_q + 1'b1;
				if (i_q == 5'(ITERS - 1))
					sine_q <= SIN_W'(y_nx) <<< 2;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign sine = sine_q;
endmodule

// ----- rtl/nci_checker.sv -----
// Port-level checker of the integrator, bound to the top level.
`include "assert_macros.svh"

module nci_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);
	// After a transaction is taken the block works on it and takes no other.
	`NCI_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted twice")

	// A flagged result always carries a zero integral.
	`NCI_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 48'd0, "invalid result not zero")

	// An item with zero panels comes back flagged when the output is free.
	`NCI_ASSERT_NXT(a_zero_fast, s_axis_tvalid && s_axis_tready && s_axis_tdata[18:8] == 11'd0 && !m_axis_tvalid, ##1 m_axis_tvalid && m_axis_tuser[0], "zero panel count not flagged")

	// A stalled result stays offered.
	`NCI_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
endmodule

bind newton_cotes_integrator_top nci_checker u_nci_checker (.*);

// ----- tb/newton_cotes_integrator_top_test.sv -----
// Self-checking testbench of the composite Newton-Cotes integrator.
module newton_cotes_integrator_top_test;
	import nci_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT_Q28    = 64'sd268435456;
	localparam longint PI_FIX      = 64'sd843314857;
	localparam longint TWO_PI_FIX  = 64'sd1686629713;
	localparam longint HALF_PI_FIX = 64'sd421657428;
	localparam longint GAIN_FIX    = 64'sd652032874;
	localparam longint FVAL_MAX    = 64'sd8796093022207;
	localparam longint FVAL_MIN    = -64'sd8796093022208;
	localparam longint SUM_MAX     = 64'sd140737488355327;
	localparam longint SUM_MIN     = -64'sd140737488355328;
	localparam int     PANEL_LIMIT = 1024;
	localparam longint ROT_ANGLE [28] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	typedef struct packed {
		logic [47:0] integral;
		logic        invalid;
	} integral_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	integral_t pending_integrals[$];
	int        fail_count = 0;
	bit        calm = 1'b0;
	int        stall_left = 0;

	newton_cotes_integrator_top u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic longint div_round(longint num, longint den);
		longint mag, q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (sh - 1));
		p = p >> sh;
		return p[63:0];
	endfunction

	function automatic longint sine_q32(longint r);
		longint x, y, z, dx, dy;
		x = GAIN_FIX;
		y = 0;
		if (r > PI_FIX) r -= TWO_PI_FIX;
		if (r > PI_FIX) r -= TWO_PI_FIX;
		if (r < -PI_FIX) r += TWO_PI_FIX;
		if (r < -PI_FIX) r += TWO_PI_FIX;
		if (r > HALF_PI_FIX) r = PI_FIX - r;
		else if (r < -HALF_PI_FIX) r = -PI_FIX - r;
		z = r;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ROT_ANGLE[i];
			end else begin
				x += dx; y -= dy; z += ROT_ANGLE[i];
			end
		end
		return y * 4;
	endfunction

	// sin(x) + x^5 in Q12.32, with the power formed on the magnitude.
	function automatic longint integrand(longint node);
		logic [63:0] mag, m2, m4, m5;
		longint f;
		mag = node < 0 ? -node : node;
		if (mag > 5 * UNIT_Q28) mag = 5 * UNIT_Q28;
		m2 = mul_shift(mag, mag, 28);
		m4 = mul_shift(m2, m2, 28);
		m5 = mul_shift(m4, mag, 24);
		f = sine_q32(node) + (node < 0 ? -longint'(m5) : longint'(m5));
		if (f > FVAL_MAX) f = FVAL_MAX;
		if (f < FVAL_MIN) f = FVAL_MIN;
		return f;
	endfunction

	function automatic integral_t predict_integral(logic [3:0] lo_b, logic [3:0] hi_b,
			logic [10:0] n_in, logic rule);
		integral_t res;
		longint lo, span, n, steps, den, total, acc, sp, j, node, w;
		lo = longint'($signed(lo_b));
		span = longint'($signed(hi_b)) - lo;
		n = n_in;
		steps = (rule == RULE_FIVE) ? 5 : 4;
		den = (rule == RULE_FIVE) ? 288 : 90;
		acc = 0;
		res = '0;
		if (n == 0) begin
			res.invalid = 1'b1;
			return res;
		end
		if (n > PANEL_LIMIT) n = PANEL_LIMIT;
		total = n * steps;
		for (longint l = 0; l < n; l++) begin
			sp = 0;
			for (int k = 0; k <= steps; k++) begin
				if (rule == RULE_FIVE)
					w = (k == 0 || k == 5) ? 19 : (k == 1 || k == 4) ? 75 : 50;
				else
					w = (k == 0 || k == 4) ? 7 : (k == 1 || k == 3) ? 32 : 12;
				j = l * steps + k;
				node = lo * UNIT_Q28 + div_round(j * span * UNIT_Q28, total);
				sp += w * integrand(node);
			end
			acc += div_round(span * sp, den * n);
		end
		if (acc > SUM_MAX) acc = SUM_MAX;
		if (acc < SUM_MIN) acc = SUM_MIN;
		res.integral = acc[47:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Sends one job; valid stays high into the next job when no gap is drawn.
	task automatic send_job(logic [3:0] lo, logic [3:0] hi, logic [10:0] n, logic rule);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, n, hi, lo};
		s_axis_tuser <= rule;
		do @(posedge clk); while (!s_axis_tready);
		pending_integrals.push_back(predict_integral(lo, hi, n, rule));
	endtask

	// Result side: field-by-field compare of each transaction, then a random stall.
	always @(posedge clk) begin
		integral_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_integrals.size() == 0) begin
				$display("unexpected result %0h at %0t", m_axis_tdata, $realtime);
				fail_count++;
			end else begin
				want = pending_integrals.pop_front();
				if (m_axis_tdata !== want.integral)
					report_mismatch("integral", m_axis_tdata, want.integral);
				if (m_axis_tuser[0] !== want.invalid)
					report_mismatch("invalid", m_axis_tuser, want.invalid);
			end
			stall_left = draw_gap();
		end else if (stall_left > 0) begin
			stall_left--;
		end
		m_axis_tready <= arst_n && (stall_left == 0);
	end

	task automatic test_zero_panels();
		send_job(4'd0, 4'd3, 11'd0, RULE_BOOLE);
		send_job(4'h8, 4'h7, 11'd0, RULE_FIVE);
	endtask

	task automatic test_limit_extremes();
		send_job(4'h8, 4'h7, 11'd1, RULE_BOOLE);
		send_job(4'h8, 4'h7, 11'd3, RULE_FIVE);
		send_job(4'h7, 4'h8, 11'd2, RULE_BOOLE);
		send_job(4'hc, 4'h4, 11'd4, RULE_FIVE);
		send_job(4'h4, 4'hc, 11'd5, RULE_BOOLE);
		send_job(4'h2, 4'h2, 11'd3, RULE_FIVE);
		send_job(4'h0, 4'h1, 11'd1, RULE_FIVE);
		send_job(4'hf, 4'h0, 11'd6, RULE_BOOLE);
	endtask

	task automatic test_panel_clamp();
		send_job(4'hd, 4'h3, 11'd2047, RULE_FIVE);
		send_job(4'h0, 4'h2, 11'd1024, RULE_BOOLE);
	endtask

	task automatic test_random_jobs();
		int n;
		for (int i = 0; i < 100; i++) begin
			if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0:       n = 0;
				1:       n = $urandom_range(13, 60);
				default: n = $urandom_range(1, 12);
			endcase
			send_job($urandom_range(0, 15), $urandom_range(0, 15), n, $urandom_range(0, 1));
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_panels();
		test_limit_extremes();
		test_panel_clamp();
		test_random_jobs();
		s_axis_tvalid <= 1'b0;
		while (pending_integrals.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#60ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
